[hdl/yuv2rgb_pkg.sv]
// Shared types, widths and chroma tables of the YUV 4:2:0 quad to RGB565 unit.
// No dependencies; every other file of the unit imports this package.

package yuv2rgb_pkg;

   localparam int SampleWidth = 8;
   localparam int TermWidth   = 9;
   localparam int SumWidth    = 11;
   localparam int PixelWidth  = 16;
   localparam int WordWidth   = 32;
   localparam int TableDepth  = 256;
   localparam int ChromaBias  = 128;
   localparam int MilliScale  = 1000;
   localparam int FineScale   = 100000;

   typedef logic [SampleWidth-1:0]        sample_type;
   typedef logic signed [TermWidth-1:0]   term_type;
   typedef logic signed [SumWidth-1:0]    sum_type;
   typedef logic [PixelWidth-1:0]         pixel_type;
   typedef logic [WordWidth-1:0]          word_type;
   typedef term_type                      term_table_type [TableDepth];

   typedef struct packed {
      term_type ub;
      term_type ug;
      term_type vg;
      term_type vr;
   } chroma_terms_type;

   // Coefficient scaled by one thousand, product truncated toward zero.
   function automatic term_table_type build_milli_table(input int coef);
      term_table_type tab;
      int             offset;
      for (int i = 0; i < TableDepth; i++) begin
         offset = i - ChromaBias;
         tab[i] = term_type'((coef * offset) / MilliScale);
      end
      return tab;
   endfunction

   // Coefficient scaled by one hundred thousand, product truncated toward zero.
   function automatic term_table_type build_fine_table(input int coef);
      term_table_type tab;
      int             offset;
      for (int i = 0; i < TableDepth; i++) begin
         offset = i - ChromaBias;
         tab[i] = term_type'((coef * offset) / FineScale);
      end
      return tab;
   endfunction

   localparam term_table_type UB_TABLE = build_milli_table(1772);
   localparam term_table_type UG_TABLE = build_fine_table(34414);
   localparam term_table_type VG_TABLE = build_fine_table(71414);
   localparam term_table_type VR_TABLE = build_milli_table(1402);

endpackage

[hdl/yuv2rgb_req_if.sv]
// Input channel of the unit: one 2x2 quad of luma with its shared chroma pair.
// Depends on yuv2rgb_pkg for the sample type.

interface yuv2rgb_req_if import yuv2rgb_pkg::*; ();
   logic       valid;
   logic       ready;
   sample_type luma_top_left;
   sample_type luma_top_right;
   sample_type luma_bottom_left;
   sample_type luma_bottom_right;
   sample_type cb_sample;
   sample_type cr_sample;

   modport source (
      output valid, luma_top_left, luma_top_right, luma_bottom_left,
             luma_bottom_right, cb_sample, cr_sample,
      input  ready
   );

   modport sink (
      input  valid, luma_top_left, luma_top_right, luma_bottom_left,
             luma_bottom_right, cb_sample, cr_sample,
      output ready
   );
endinterface

[hdl/yuv2rgb_rsp_if.sv]
// Result channel of the unit: two packed RGB565 row words per quad.
// Depends on yuv2rgb_pkg for the word type.

interface yuv2rgb_rsp_if import yuv2rgb_pkg::*; ();
   logic     valid;
   logic     ready;
   word_type top_word;
   word_type bottom_word;

   modport source (
      output valid, top_word, bottom_word,
      input  ready
   );

   modport sink (
      input  valid, top_word, bottom_word,
      output ready
   );
endinterface

[hdl/yuv2rgb_pixel.sv]
// Converts one luma sample with the quad's chroma terms into an RGB565 pixel.
// Depends on yuv2rgb_pkg for the term struct and widths.

module yuv2rgb_pixel import yuv2rgb_pkg::*; (
   input  sample_type       luma,
   input  chroma_terms_type terms,
   output pixel_type        pixel
);

   sum_type    luma_ext;
   sum_type    blue_sum;
   sum_type    green_sum;
   sum_type    red_sum;
   sample_type blue;
   sample_type green;
   sample_type red;

   function automatic sample_type clamp_byte(input sum_type value);
      sample_type result;
      if (value < 0) begin
         result = '0;
      end else if (value > sum_type'(255)) begin
         result = '1;
      end else begin
         result = value[SampleWidth-1:0];
      end
      return result;
   endfunction

   assign luma_ext  = sum_type'({1'b0, luma});
   assign blue_sum  = luma_ext + sum_type'(terms.ub);
   assign green_sum = luma_ext - sum_type'(terms.ug) - sum_type'(terms.vg);
   assign red_sum   = luma_ext + sum_type'(terms.vr);

   assign blue  = clamp_byte(blue_sum);
   assign green = clamp_byte(green_sum);
   assign red   = clamp_byte(red_sum);

   assign pixel = {red[7:3], green[7:2], blue[7:3]};

endmodule

[hdl/yuv420_quad_to_rgb565_unit.sv]
// YUV 4:2:0 quad to RGB565 converter, top level.
// Depends on yuv2rgb_pkg, yuv2rgb_req_if, yuv2rgb_rsp_if and yuv2rgb_pixel.
//
// The req_ch channel takes one 2x2 quad per transfer: four luma samples and the
// shared Cb and Cr bytes. The rsp_ch channel returns one transfer per quad: the
// top and bottom row words, each with the left pixel in bits 15:0 and the right
// pixel in bits 31:16, in RGB565.
// The chroma terms are read from constant tables as the quad enters the input
// register; the additions, clamping and packing lie between the input register
// and the result register. One quad can be transferred in every cycle while
// the receiver keeps rsp_ch.ready high.
// Reset clears both valid flags; the block then accepts a quad at once.
// When the receiver stalls, the result register holds its word and the input
// register still takes one more quad, so two quads are held before req_ch.ready
// falls. Each register advances as soon as the one behind it frees.

module yuv420_quad_to_rgb565_unit import yuv2rgb_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   yuv2rgb_req_if.sink   req_ch,
   yuv2rgb_rsp_if.source rsp_ch
);

   logic             in_valid_ff;
   logic             in_valid_in;
   sample_type       luma_ff [4];
   chroma_terms_type terms_ff;
   chroma_terms_type terms_in;
   logic             out_valid_ff;
   logic             out_valid_in;
   word_type         top_word_ff;
   word_type         bottom_word_ff;
   pixel_type        pixels [4];
   logic             in_ready;
   logic             out_ready;
   logic             req_transfer;
   logic             stage_transfer;

   assign out_ready      = !out_valid_ff || rsp_ch.ready;
   assign in_ready       = !in_valid_ff || out_ready;
   assign req_transfer   = req_ch.valid && in_ready;
   assign stage_transfer = in_valid_ff && out_ready;

   assign req_ch.ready = in_ready;

   assign terms_in.ub = UB_TABLE[req_ch.cb_sample];
   assign terms_in.ug = UG_TABLE[req_ch.cb_sample];
   assign terms_in.vg = VG_TABLE[req_ch.cr_sample];
   assign terms_in.vr = VR_TABLE[req_ch.cr_sample];

   assign in_valid_in  = in_ready ? req_ch.valid : in_valid_ff;
   assign out_valid_in = out_ready ? in_valid_ff : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_transfer) begin
         luma_ff[0] <= req_ch.luma_top_left;
         luma_ff[1] <= req_ch.luma_top_right;
         luma_ff[2] <= req_ch.luma_bottom_left;
         luma_ff[3] <= req_ch.luma_bottom_right;
         terms_ff   <= terms_in;
      end
   end

   for (genvar p = 0; p < 4; p++) begin : g_pixel
      yuv2rgb_pixel u_pixel (
         .luma  (luma_ff[p]),
         .terms (terms_ff),
         .pixel (pixels[p])
      );
   end

   always_ff @(posedge clock) begin
      if (stage_transfer) begin
         top_word_ff    <= {pixels[1], pixels[0]};
         bottom_word_ff <= {pixels[3], pixels[2]};
      end
   end

   assign rsp_ch.valid       = out_valid_ff;
   assign rsp_ch.top_word    = top_word_ff;
   assign rsp_ch.bottom_word = bottom_word_ff;

   // A transferred quad always lands in the input register.
   assert property (@(posedge clock) disable iff (reset)
      req_transfer |=> in_valid_ff)
      else $error("transferred quad not held in the input register");

   // A held quad that moves on always fills the result register.
   assert property (@(posedge clock) disable iff (reset)
      stage_transfer |=> out_valid_ff)
      else $error("quad lost between input and result registers");

   // A blocked quad keeps its chroma terms until the result register frees.
   assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !out_ready) |=> (in_valid_ff && $stable(terms_ff)))
      else $error("blocked quad changed in the input register");

   // With both registers empty the block must take a quad.
   assert property (@(posedge clock) disable iff (reset)
      (!in_valid_ff && !out_valid_ff) |-> req_ch.ready)
      else $error("empty pipeline refuses a quad");

endmodule
